/* hdl/kmpq_pkg.sv */
// ----------------------------------------------------------------------------
// kmpq_pkg
// Shared types, codes and the entry ordering function of the k-way merge
// priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kmpq_pkg;

  localparam int unsigned MaxSources   = 16;
  localparam int unsigned ValueBits    = 32;
  localparam int unsigned SourceBits   = 4;
  localparam int unsigned PositionBits = 24;
  localparam int unsigned LeftBits     = 5;

  typedef enum logic [1:0] {
    KindInsert    = 2'd0,
    KindPopRefill = 2'd1,
    KindPopOnly   = 2'd2,
    KindUnused    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OpHold      = 2'd0,
    OpInsert    = 2'd1,
    OpPopRefill = 2'd2,
    OpPopOnly   = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic [SourceBits-1:0]       source;
    logic [PositionBits-1:0]     position;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [ValueBits-1:0] new_value;
    logic [SourceBits-1:0]       source_id;
  } in_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] popped_value;
    logic [SourceBits-1:0]       popped_source;
    logic [PositionBits-1:0]     popped_position;
    logic [1:0]                  status;
    logic [LeftBits-1:0]         entries_left;
  } out_t;

  // true if a orders strictly before b: value, then source, then position
  function automatic logic entry_before(entry_t a, entry_t b);
    logic res;
    if (a.value != b.value) begin
      res = (a.value < b.value);
    end else if (a.source != b.source) begin
      res = (a.source < b.source);
    end else begin
      res = (a.position < b.position);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/kmpq_cell.sv */
// ----------------------------------------------------------------------------
// kmpq_cell
// One slot of the sorted entry chain. Compares its entry with the broadcast
// entry and takes its own, its neighbor's or the broadcast entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kmpq_cell
  import kmpq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire logic      head_i,
  input  wire logic      occupied_i,
  input  wire logic      left_flag_i,
  input  wire logic      right_flag_i,
  input  wire entry_t    left_ent_i,
  input  wire entry_t    right_ent_i,
  output entry_t         ent_o,
  output logic           flag_o
);

  entry_t ent_q, ent_d;

  // set when this slot holds an entry that orders before the broadcast one
  assign flag_o = occupied_i && entry_before(ent_q, ctl_i.ent);
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    unique case (ctl_i.op)
      OpInsert: begin
        if (flag_o) begin
          ent_d = ent_q;
        end else if (left_flag_i) begin
          ent_d = ctl_i.ent;
        end else begin
          ent_d = left_ent_i;
        end
      end
      OpPopRefill: begin
        if (right_flag_i) begin
          ent_d = right_ent_i;
        end else if (head_i || flag_o) begin
          ent_d = ctl_i.ent;
        end else begin
          ent_d = ent_q;
        end
      end
      OpPopOnly: ent_d = right_ent_i;
      OpHold:    ent_d = ent_q;
      default:   ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

/* hdl/k_way_merge_priority_queue.sv */
// ----------------------------------------------------------------------------
// k_way_merge_priority_queue
// Min priority queue of run heads for a k-way merge, built as a sorted chain
// of cells.
// ----------------------------------------------------------------------------
// Usage: entries are kept sorted in a chain of MAX_SOURCES cells, the least at
// cell 0. Every item (insert, pop and refill, pop only) is broadcast to all
// cells, which compare it with their entry and shift by one place in the same
// cycle, so the block takes one item per cycle while the output is not stalled
// and returns its result in the cycle after acceptance; the rate is set by the
// per-cell compare against the broadcast entry. A single output register holds
// the result: while it is stalled the input stalls too, and a new item can
// enter in the cycle the waiting result leaves. Ordering is by value, then
// lower source, then lower position.
`default_nettype none

module k_way_merge_priority_queue
  import kmpq_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = MaxSources
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

  localparam int unsigned CntW = $clog2(MAX_SOURCES + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  out_t            out_q, out_d;
  logic            accept;
  cell_ctl_t       ctl;
  entry_t          cell_ent [MAX_SOURCES];
  logic            cell_flag [MAX_SOURCES];
  logic            is_empty, is_full;
  entry_t          head;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(MAX_SOURCES));
  assign head     = cell_ent[0];

  always_comb begin
    ctl.op   = OpHold;
    ctl.ent  = '{value: in_i.new_value, source: in_i.source_id, position: '0};
    count_d  = count_q;
    out_d    = '0;
    unique case (in_i.kind)
      KindInsert: begin
        if (is_full) begin
          out_d.status = StatusFull;
        end else begin
          ctl.op  = OpInsert;
          count_d = count_q + 1'b1;
        end
      end
      KindPopRefill, KindPopOnly: begin
        if (is_empty) begin
          out_d.status = StatusEmpty;
        end else begin
          out_d.popped_value    = head.value;
          out_d.popped_source   = head.source;
          out_d.popped_position = head.position;
          ctl.ent.source        = head.source;
          ctl.ent.position      = (head.position == '1) ? head.position
                                                        : head.position + 1'b1;
          if (in_i.kind == KindPopRefill) begin
            ctl.op = OpPopRefill;
          end else begin
            ctl.op  = OpPopOnly;
            count_d = count_q - 1'b1;
          end
        end
      end
      default: ctl.op = OpHold;
    endcase
    if (!accept) begin
      ctl.op  = OpHold;
      count_d = count_q;
    end
    out_d.entries_left = LeftBits'(count_d);
  end

  for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
    logic   left_flag, right_flag, occupied;
    entry_t left_ent, right_ent;

    assign occupied = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_flag = 1'b1;
      assign left_ent  = '0;
    end else begin : g_mid
      assign left_flag = cell_flag[i-1];
      assign left_ent  = cell_ent[i-1];
    end

    if (i == MAX_SOURCES - 1) begin : g_last
      assign right_flag = 1'b0;
      assign right_ent  = '0;
    end else begin : g_inner
      assign right_flag = cell_flag[i+1];
      assign right_ent  = cell_ent[i+1];
    end

    kmpq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .head_i       (i == 0),
      .occupied_i   (occupied),
      .left_flag_i  (left_flag),
      .right_flag_i (right_flag),
      .left_ent_i   (left_ent),
      .right_ent_i  (right_ent),
      .ent_o        (cell_ent[i]),
      .flag_o       (cell_flag[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SOURCES))
    else $error("entry count above capacity");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(2) |-> !entry_before(cell_ent[1], cell_ent[0]))
    else $error("head cell not the least entry");

  a_pop_only_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ctl.op == OpPopOnly |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not lower entry count");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && out_q.entries_left == LeftBits'(count_q))
    else $error("accepted item produced no matching result");
`endif

endmodule

`default_nettype wire

/* tb/k_way_merge_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// k_way_merge_priority_queue_tb
// Self-checking bench for the k-way merge priority queue. A queue of items
// (directed corner cases, then random fill, drain and merge phases) feeds a
// clocked driver. Each accepted item runs through a local queue of run heads
// that predicts the result. A clocked monitor checks every result against the
// oldest prediction. Both sides idle at random, and the receiver holds off
// once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module k_way_merge_priority_queue_tb;
  import kmpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandomItems = 750;
  localparam int unsigned HoldOffCycles  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_t out_item;

  in_t  merge_items_q[$];
  out_t merge_results_q[$];

  entry_t      run_heads[MaxSources];
  int unsigned head_count = 0;

  int unsigned send_gap = 0;
  int unsigned calm_items = 0;
  int unsigned stall_left = 0;
  int unsigned calm_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  logic        in_fire;

  k_way_merge_priority_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit orders_first(entry_t a, entry_t b);
    if ($signed(a.value) != $signed(b.value)) begin
      return $signed(a.value) < $signed(b.value);
    end
    if (a.source != b.source) begin
      return a.source < b.source;
    end
    return a.position < b.position;
  endfunction

  function automatic out_t merge_step(in_t it);
    out_t        res;
    int unsigned best;
    entry_t      top;
    res = '0;
    case (kind_e'(it.kind))
      KindInsert: begin
        if (head_count >= MaxSources) begin
          res.status = StatusFull;
        end else begin
          run_heads[head_count] = '{value: it.new_value, source: it.source_id, position: '0};
          head_count++;
        end
      end
      KindPopRefill, KindPopOnly: begin
        if (head_count == 0) begin
          res.status = StatusEmpty;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < head_count; i++) begin
            if (orders_first(run_heads[i], run_heads[best])) best = i;
          end
          top = run_heads[best];
          head_count--;
          run_heads[best] = run_heads[head_count];
          res.popped_value    = top.value;
          res.popped_source   = top.source;
          res.popped_position = top.position;
          if (kind_e'(it.kind) == KindPopRefill) begin
            run_heads[head_count].value    = it.new_value;
            run_heads[head_count].source   = top.source;
            run_heads[head_count].position = (&top.position) ? top.position
                                                              : top.position + 1'b1;
            head_count++;
          end
        end
      end
      default: ;
    endcase
    res.entries_left = head_count[LeftBits-1:0];
    return res;
  endfunction

  function automatic logic [ValueBits-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(ValueBits-1){1'b0}}};
      1:       return {1'b0, {(ValueBits-1){1'b1}}};
      2, 3, 4: return ValueBits'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(kind_e k, logic [ValueBits-1:0] v, logic [SourceBits-1:0] s);
    in_t it;
    it.kind      = k;
    it.new_value = v;
    it.source_id = s;
    merge_items_q.push_back(it);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      send_gap <= 0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) merge_results_q.push_back(merge_step(in_item));
      if (in_valid && !in_fire) begin
        // hold the stalled item
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (merge_items_q.size() > 0) begin
        in_valid <= 1'b1;
        in_item  <= merge_items_q[0];
        merge_items_q.delete(0);
        if (calm_items > 0) begin
          calm_items <= calm_items - 1;
          send_gap   <= 0;
        end else begin
          case ($urandom_range(0, 19))
            0:             calm_items <= 40;
            1, 2:          send_gap <= $urandom_range(10, 40);
            3, 4, 5, 6, 7: send_gap <= $urandom_range(1, 3);
            default:       send_gap <= 0;
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (merge_results_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %p", out_item);
        end else begin
          if (out_item !== merge_results_q[0]) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected value %0d src %0d pos %0d status %0d left %0d",
                       $signed(merge_results_q[0].popped_value),
                       merge_results_q[0].popped_source, merge_results_q[0].popped_position,
                       merge_results_q[0].status, merge_results_q[0].entries_left);
              $display("          actual   value %0d src %0d pos %0d status %0d left %0d",
                       $signed(out_item.popped_value), out_item.popped_source,
                       out_item.popped_position, out_item.status, out_item.entries_left);
            end
          end
          merge_results_q.delete(0);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 120) begin
        hold_done <= 1'b1;
        hold_left <= HoldOffCycles;
        out_stall <= 1'b1;
      end else if (calm_cycles > 0) begin
        out_stall   <= 1'b0;
        calm_cycles <= calm_cycles - 1;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            out_stall   <= 1'b0;
            calm_cycles <= 50;
          end
          1: begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 30);
          end
          2, 3, 4, 5: begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned seg_len;
    int unsigned pick;
    int unsigned made;

    // empty queue, unused kind
    add_item(KindPopOnly, 32'd5, 4'd1);
    add_item(KindPopRefill, 32'd9, 4'd2);
    add_item(KindUnused, 32'hFFFF_FFFF, 4'hF);
    // extremes and ties
    add_item(KindInsert, 32'h7FFF_FFFF, 4'hF);
    add_item(KindInsert, 32'h8000_0000, 4'h0);
    add_item(KindInsert, 32'd0, 4'd7);
    add_item(KindInsert, 32'd0, 4'd3);
    add_item(KindInsert, 32'hFFFF_FFFF, 4'd9);
    add_item(KindInsert, 32'd0, 4'd3);
    add_item(KindUnused, 32'd0, 4'd0);
    add_item(KindPopRefill, 32'h7FFF_FFFF, 4'd0);
    add_item(KindPopRefill, 32'h8000_0000, 4'd0);
    add_item(KindPopRefill, 32'hFFFF_FFFF, 4'd0);
    add_item(KindPopRefill, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);
    add_item(KindPopRefill, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);
    add_item(KindPopOnly, 32'd0, 4'd0);

    // random phases: fill, drain and merge
    made = 0;
    while (made < NumRandomItems) begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 60);
      for (int unsigned n = 0; n < seg_len; n++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0: begin
            if (pick < 65)      add_item(KindInsert, rand_value(), SourceBits'($urandom));
            else if (pick < 85) add_item(KindPopRefill, rand_value(), SourceBits'($urandom));
            else if (pick < 97) add_item(KindPopOnly, rand_value(), SourceBits'($urandom));
            else                add_item(KindUnused, rand_value(), SourceBits'($urandom));
          end
          1: begin
            if (pick < 60)      add_item(KindPopOnly, rand_value(), SourceBits'($urandom));
            else if (pick < 85) add_item(KindPopRefill, rand_value(), SourceBits'($urandom));
            else if (pick < 97) add_item(KindInsert, rand_value(), SourceBits'($urandom));
            else                add_item(KindUnused, rand_value(), SourceBits'($urandom));
          end
          default: begin
            if (pick < 75)      add_item(KindPopRefill, rand_value(), SourceBits'($urandom));
            else if (pick < 86) add_item(KindInsert, rand_value(), SourceBits'($urandom));
            else if (pick < 97) add_item(KindPopOnly, rand_value(), SourceBits'($urandom));
            else                add_item(KindUnused, rand_value(), SourceBits'($urandom));
          end
        endcase
      end
      made += seg_len;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (merge_items_q.size() != 0 || in_valid || merge_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (errors == 0 && merge_results_q.size() == 0) begin
      $display("** k_way_merge_priority_queue: PASSED **");
    end else begin
      $display("** k_way_merge_priority_queue: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("** k_way_merge_priority_queue: FAILED **");
    $finish;
  end

endmodule
